### rtl/core/aslc_pkg.sv
// Package for the aligned section layout checker.
// Holds the layout constants, the item and stage payload types and the start cursor function.
// It depends on nothing else.
package aslc_pkg;

    localparam int HDR_SIZE     = 256;
    localparam int ENTRY_BYTES  = 128;
    localparam int MIN_ALIGN    = 64;
    localparam int MAX_SECTIONS = 256;

    localparam int CNT_W = 9;
    localparam int W     = 64;
    localparam int HW    = W / 2;

    typedef struct packed {
        logic         has_data;
        logic [W-1:0] section_bytes;
        logic [W-1:0] section_alignment;
        logic [W-1:0] record_size;
        logic [W-1:0] record_total;
    } t_item;

    typedef struct packed {
        logic         has_data;
        logic [W-1:0] section_bytes;
        logic [W-1:0] section_alignment;
        logic [W-1:0] pp_ll;
        logic [W-1:0] pp_hl;
        logic [W-1:0] pp_lh;
        logic         hi_both;
        logic         rsize_zero;
        logic         rtotal_zero;
    } t_prod;

    typedef struct packed {
        logic [W-1:0] section_bytes;
        logic [W-1:0] align_mask;
        logic         item_ok;
    } t_chk;

    typedef struct packed {
        logic [W-1:0] section_offset;
        logic         status;
        logic [W-1:0] layout_total;
        logic         batch_last;
    } t_result;

    function automatic logic [W-1:0] start_cursor(input logic [CNT_W-1:0] count);
        logic [W-1:0] dir_bytes;
        dir_bytes = {{(W-CNT_W){1'b0}}, count} * W'(ENTRY_BYTES);
        return W'(HDR_SIZE) + dir_bytes;
    endfunction

endpackage

### rtl/core/aligned_section_layout_checker.sv
// Top level of the aligned section layout checker.
// Chains the product stage, the rule stage and the placement stage; depends on aslc_pkg.
//
// One section descriptor enters per item on the slave stream and one result item leaves
// on the master stream for each of them, in order. The section count is written through
// i_cfg_we and i_cfg_wdata; the user must do so only while the block is idle, which the
// block does not enforce. A batch is that many items long (one for count 0); the last
// result of a batch carries tlast and, if the batch is valid, the total file size. The
// offsets start after the header and the directory and restart on every batch. After
// the first bad section every remaining item of the batch reports status 1. Items pass
// the input, product, rule and result registers. Throughput is one item per cycle when
// not stalled: the cursor add and align in the placement stage is the only loop, while
// the 64 by 64 record product is built from three 32 by 32 partial products and summed
// in the stage ahead of it. Each stage holds its item while the next one is full, so a
// stalled receiver fills the pipeline and then holds tready low; nothing is dropped.
// Reset empties the pipeline, sets the section count to one and restarts the batch.
module aligned_section_layout_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [8:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // section_bytes, section_alignment, record_size, record_total
    input  logic [255:0] s_axis_tdata,
    // has_data
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // section_offset, layout_total
    output logic [127:0] m_axis_tdata,
    // status
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);

    aslc_pkg::t_item   item;
    aslc_pkg::t_prod   prod;
    aslc_pkg::t_chk    chk;
    aslc_pkg::t_result result;
    logic              prod_valid;
    logic              chk_valid;
    logic              rule_ready;
    logic              place_ready;

    always_comb begin
        item.has_data          = s_axis_tuser;
        item.section_bytes     = s_axis_tdata[63:0];
        item.section_alignment = s_axis_tdata[127:64];
        item.record_size       = s_axis_tdata[191:128];
        item.record_total      = s_axis_tdata[255:192];
    end

    aslc_mul_stage u_mul (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_item       (item),
        .o_valid      (prod_valid),
        .i_next_ready (rule_ready),
        .o_prod       (prod)
    );

    aslc_rule_stage u_rule (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (prod_valid),
        .o_ready      (rule_ready),
        .i_prod       (prod),
        .o_valid      (chk_valid),
        .i_next_ready (place_ready),
        .o_chk        (chk)
    );

    aslc_place u_place (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (chk_valid),
        .o_ready     (place_ready),
        .i_chk       (chk),
        .o_valid     (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = {result.layout_total, result.section_offset};
    assign m_axis_tuser = result.status;
    assign m_axis_tlast = result.batch_last;

endmodule

### rtl/core/aslc_mul_stage.sv
// Input register and record product stage of the layout checker.
// Splits record_size times record_total into three registered 32 by 32 partial products
// and a flag for the high pair. Depends on aslc_pkg.
module aslc_mul_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  aslc_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_next_ready,
    output aslc_pkg::t_prod   o_prod
);

    logic            r_in_valid;
    aslc_pkg::t_item r_item;
    logic            r_pp_valid;
    aslc_pkg::t_prod r_prod;
    aslc_pkg::t_prod n_prod;
    logic            pp_en;
    logic            in_en;

    assign pp_en      = !r_pp_valid || i_next_ready;
    assign in_en      = !r_in_valid || pp_en;
    assign o_in_ready = in_en;

    always_comb begin
        n_prod.has_data          = r_item.has_data;
        n_prod.section_bytes     = r_item.section_bytes;
        n_prod.section_alignment = r_item.section_alignment;
        n_prod.pp_ll = aslc_pkg::W'(r_item.record_size[aslc_pkg::HW-1:0])
                     * aslc_pkg::W'(r_item.record_total[aslc_pkg::HW-1:0]);
        n_prod.pp_hl = aslc_pkg::W'(r_item.record_size[aslc_pkg::W-1:aslc_pkg::HW])
                     * aslc_pkg::W'(r_item.record_total[aslc_pkg::HW-1:0]);
        n_prod.pp_lh = aslc_pkg::W'(r_item.record_size[aslc_pkg::HW-1:0])
                     * aslc_pkg::W'(r_item.record_total[aslc_pkg::W-1:aslc_pkg::HW]);
        n_prod.hi_both = (r_item.record_size[aslc_pkg::W-1:aslc_pkg::HW] != '0)
                      && (r_item.record_total[aslc_pkg::W-1:aslc_pkg::HW] != '0);
        n_prod.rsize_zero  = (r_item.record_size == '0);
        n_prod.rtotal_zero = (r_item.record_total == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pp_valid <= 1'b0;
        end else begin
            if (in_en) begin
                r_in_valid <= i_in_valid;
            end
            if (pp_en) begin
                r_pp_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_en && i_in_valid) begin
            r_item <= i_item;
        end
        if (pp_en && r_in_valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_pp_valid;
    assign o_prod  = r_prod;

endmodule

### rtl/core/aslc_rule_stage.sv
// Section rule stage of the layout checker.
// Finishes the record product and checks every rule that needs neither the cursor
// nor the section count. Depends on aslc_pkg.
module aslc_rule_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  aslc_pkg::t_prod i_prod,
    output logic            o_valid,
    input  logic            i_next_ready,
    output aslc_pkg::t_chk  o_chk
);

    logic                  r_valid;
    aslc_pkg::t_chk        r_chk;
    aslc_pkg::t_chk        n_chk;
    logic                  en;
    logic [aslc_pkg::W:0]  mid_sum;
    logic [aslc_pkg::W:0]  full_sum;
    logic                  prod_ovf;
    logic                  prod_ok;
    logic [aslc_pkg::W-1:0] align;
    logic [aslc_pkg::W-1:0] mask;
    logic                  align_ok;

    assign en      = !r_valid || i_next_ready;
    assign o_ready = en;

    always_comb begin
        mid_sum  = {1'b0, i_prod.pp_hl} + {1'b0, i_prod.pp_lh};
        full_sum = {1'b0, i_prod.pp_ll}
                 + {1'b0, mid_sum[aslc_pkg::HW-1:0], {aslc_pkg::HW{1'b0}}};
        prod_ovf = i_prod.hi_both || (mid_sum[aslc_pkg::W:aslc_pkg::HW] != '0)
                || full_sum[aslc_pkg::W];
        prod_ok  = !prod_ovf && (full_sum[aslc_pkg::W-1:0] == i_prod.section_bytes);

        align    = i_prod.section_alignment;
        mask     = align - aslc_pkg::W'(1);
        align_ok = (align != '0) && ((align & mask) == '0)
                && (align >= aslc_pkg::W'(aslc_pkg::MIN_ALIGN));

        n_chk.section_bytes = i_prod.section_bytes;
        n_chk.align_mask    = mask;
        n_chk.item_ok = i_prod.has_data && (i_prod.section_bytes != '0) && align_ok
                     && (i_prod.rsize_zero == i_prod.rtotal_zero)
                     && (i_prod.rsize_zero || prod_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_chk <= n_chk;
        end
    end

    assign o_valid = r_valid;
    assign o_chk   = r_chk;

endmodule

### rtl/core/aslc_place.sv
// Placement stage of the layout checker.
// Holds the section count register, the cursor, the batch state and the result register.
// Depends on aslc_pkg.
module aslc_place (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [aslc_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  aslc_pkg::t_chk                i_chk,
    output logic                          o_valid,
    input  logic                          i_out_ready,
    output aslc_pkg::t_result             o_result
);

    logic [aslc_pkg::CNT_W-1:0] r_count;
    logic [aslc_pkg::W-1:0]     r_cursor;
    logic [aslc_pkg::CNT_W-1:0] r_index;
    logic                       r_failed;
    logic                       r_out_valid;
    aslc_pkg::t_result          r_result;

    logic [aslc_pkg::W-1:0]     n_cursor;
    logic [aslc_pkg::CNT_W-1:0] n_index;
    logic                       n_failed;
    aslc_pkg::t_result          n_result;

    logic                       en;
    logic                       take;
    logic [aslc_pkg::W-1:0]     start;
    logic                       first;
    logic [aslc_pkg::W-1:0]     cur;
    logic                       failed;
    logic                       count_bad;
    logic                       last;
    logic [aslc_pkg::W:0]       up_sum;
    logic [aslc_pkg::W-1:0]     offset;
    logic [aslc_pkg::W:0]       end_sum;
    logic                       ok;

    assign en      = !r_out_valid || i_out_ready;
    assign take    = en && i_valid;
    assign o_ready = en;

    always_comb begin
        start     = aslc_pkg::start_cursor(r_count);
        first     = (r_index == '0);
        cur       = first ? start : r_cursor;
        failed    = first ? 1'b0 : r_failed;
        count_bad = (r_count == '0)
                 || ({1'b0, r_count} > (aslc_pkg::CNT_W+1)'(aslc_pkg::MAX_SECTIONS));
        last      = ({1'b0, r_index} + (aslc_pkg::CNT_W+1)'(1)) >= {1'b0, r_count};

        up_sum  = {1'b0, cur} + {1'b0, i_chk.align_mask};
        offset  = up_sum[aslc_pkg::W-1:0] & ~i_chk.align_mask;
        end_sum = {1'b0, offset} + {1'b0, i_chk.section_bytes};
        ok      = !count_bad && !failed && i_chk.item_ok
               && !up_sum[aslc_pkg::W] && !end_sum[aslc_pkg::W];

        n_result.section_offset = ok ? offset : '0;
        n_result.status         = !ok;
        n_result.layout_total   = (ok && last) ? end_sum[aslc_pkg::W-1:0] : '0;
        n_result.batch_last     = last;

        if (last) begin
            n_index  = '0;
            n_failed = 1'b0;
            n_cursor = start;
        end else begin
            n_index  = r_index + aslc_pkg::CNT_W'(1);
            n_failed = failed || !ok;
            n_cursor = ok ? end_sum[aslc_pkg::W-1:0] : cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= aslc_pkg::CNT_W'(1);
            r_cursor    <= aslc_pkg::W'(aslc_pkg::HDR_SIZE + aslc_pkg::ENTRY_BYTES);
            r_index     <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (take) begin
                r_cursor <= n_cursor;
                r_index  <= n_index;
                r_failed <= n_failed;
            end
            if (en) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

### verif/aslc_layout_check.sv
// Checker for the aligned section layout checker: watches the config port and both streams.
// Predicts each result from its own copy of the batch state and compares it field by field.
// Depends on aslc_pkg for the layout constants and the item and result types.
module aslc_layout_check (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [8:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [127:0] m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         m_axis_tlast,
    output int           o_fault_total,
    output int           o_results_owed
);

    logic [aslc_pkg::CNT_W-1:0] count_reg;
    logic [aslc_pkg::W-1:0]     cursor;
    logic [aslc_pkg::CNT_W-1:0] index;
    logic                       failed;
    aslc_pkg::t_result          awaited[$];
    int                         errors = 0;

    assign o_fault_total = errors;

    function automatic logic [aslc_pkg::W-1:0] dir_end(input logic [aslc_pkg::CNT_W-1:0] n);
        return aslc_pkg::W'(aslc_pkg::HDR_SIZE)
             + aslc_pkg::W'(n) * aslc_pkg::W'(aslc_pkg::ENTRY_BYTES);
    endfunction

    // Applies the section rules and gives the aligned offset when the cursor can be aligned.
    function automatic logic fits_rules(input aslc_pkg::t_item it,
                                        input logic [aslc_pkg::W-1:0] at,
                                        output logic [aslc_pkg::W-1:0] placed);
        logic [aslc_pkg::W-1:0]   mask;
        logic [2*aslc_pkg::W-1:0] prod;
        placed = '0;
        mask = it.section_alignment - aslc_pkg::W'(1);
        prod = {{aslc_pkg::W{1'b0}}, it.record_size} * {{aslc_pkg::W{1'b0}}, it.record_total};
        if (!it.has_data || it.section_bytes == '0) return 1'b0;
        if (it.section_alignment == '0 || (it.section_alignment & mask) != '0) return 1'b0;
        if (it.section_alignment < aslc_pkg::W'(aslc_pkg::MIN_ALIGN)) return 1'b0;
        if (at > ~mask) return 1'b0;
        placed = (at + mask) & ~mask;
        if (it.section_bytes > ~placed) return 1'b0;
        if ((it.record_size == '0) != (it.record_total == '0)) return 1'b0;
        if (it.record_size != '0 && (prod[2*aslc_pkg::W-1:aslc_pkg::W] != '0
                                     || prod[aslc_pkg::W-1:0] != it.section_bytes))
            return 1'b0;
        return 1'b1;
    endfunction

    task automatic judge(input string field, input logic [aslc_pkg::W-1:0] want_v,
                         input logic [aslc_pkg::W-1:0] got_v);
        if (want_v !== got_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : track
        aslc_pkg::t_item        it;
        aslc_pkg::t_result      want;
        logic [aslc_pkg::W-1:0] placed;
        logic                   rule_ok;
        logic                   good;
        logic                   closing;
        logic                   count_bad;
        if (!i_rst_n) begin
            count_reg = aslc_pkg::CNT_W'(1);
            cursor    = aslc_pkg::W'(aslc_pkg::HDR_SIZE + aslc_pkg::ENTRY_BYTES);
            index     = '0;
            failed    = 1'b0;
            awaited.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing awaited, expected none, actual %0h",
                             $time, m_axis_tdata);
                end else begin
                    want = awaited.pop_front();
                    judge("section_offset", want.section_offset, m_axis_tdata[63:0]);
                    judge("status", aslc_pkg::W'(want.status), aslc_pkg::W'(m_axis_tuser));
                    judge("layout_total", want.layout_total, m_axis_tdata[127:64]);
                    judge("batch_last", aslc_pkg::W'(want.batch_last),
                          aslc_pkg::W'(m_axis_tlast));
                end
            end
            if (i_cfg_we) count_reg = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                it.has_data          = s_axis_tuser;
                it.section_bytes     = s_axis_tdata[63:0];
                it.section_alignment = s_axis_tdata[127:64];
                it.record_size       = s_axis_tdata[191:128];
                it.record_total      = s_axis_tdata[255:192];
                count_bad = count_reg == '0 || count_reg > aslc_pkg::MAX_SECTIONS;
                closing   = ({1'b0, index} + 10'd1) >= {1'b0, count_reg};
                if (index == '0) begin
                    cursor = dir_end(count_reg);
                    failed = 1'b0;
                end
                rule_ok = fits_rules(it, cursor, placed);
                good    = !count_bad && !failed && rule_ok;
                if (good) cursor = placed + it.section_bytes;
                else      failed = 1'b1;
                want.section_offset = good ? placed : '0;
                want.status         = !good;
                want.layout_total   = (good && closing) ? cursor : '0;
                want.batch_last     = closing;
                awaited.push_back(want);
                if (closing) begin
                    index  = '0;
                    failed = 1'b0;
                    cursor = dir_end(count_reg);
                end else begin
                    index = index + 1'b1;
                end
            end
        end
        o_results_owed <= awaited.size();
    end

endmodule

### verif/aligned_section_layout_checker_tb.sv
// Testbench top for the aligned section layout checker: clock, reset, stimulus and verdict.
// Drives directed and random section batches under random idling on both streams.
// Depends on aslc_pkg, the block itself and the aslc_layout_check module.
module aligned_section_layout_checker_tb;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [8:0]   i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    int   fault_total;
    int   results_owed;
    int   sent = 0;
    logic calm = 1'b0;
    logic tx_gappy = 1'b1;
    logic hold_req = 1'b0;
    logic hold_used = 1'b0;

    always #4 i_clk = ~i_clk;

    aligned_section_layout_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    aslc_layout_check layout_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .o_fault_total  (fault_total),
        .o_results_owed (results_owed)
    );

    function automatic logic [aslc_pkg::W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic aslc_pkg::t_item section(input logic has,
                                                input logic [aslc_pkg::W-1:0] bytes,
                                                input logic [aslc_pkg::W-1:0] align,
                                                input logic [aslc_pkg::W-1:0] rsize,
                                                input logic [aslc_pkg::W-1:0] rtotal);
        aslc_pkg::t_item it;
        it.has_data          = has;
        it.section_bytes     = bytes;
        it.section_alignment = align;
        it.record_size       = rsize;
        it.record_total      = rtotal;
        return it;
    endfunction

    // A well-formed section, so that batches mostly run to their end.
    function automatic aslc_pkg::t_item tidy_section();
        aslc_pkg::t_item it;
        int              top_shift;
        top_shift = ($urandom_range(0, 9) == 0) ? 40 : 12;
        it = section(1'b1, aslc_pkg::W'(1), aslc_pkg::W'(1) << $urandom_range(6, top_shift),
                     '0, '0);
        case ($urandom_range(0, 2))
            0: it.section_bytes = aslc_pkg::W'($urandom_range(1, 5000));
            1: begin
                it.record_size   = aslc_pkg::W'($urandom_range(1, 256));
                it.record_total  = aslc_pkg::W'($urandom_range(1, 64));
                it.section_bytes = it.record_size * it.record_total;
            end
            default: it.section_bytes = {30'd0, 2'($urandom_range(0, 3)), $urandom} + 1'b1;
        endcase
        return it;
    endfunction

    // A section with one field broken, or with every field random.
    function automatic aslc_pkg::t_item rough_section();
        aslc_pkg::t_item it;
        it = tidy_section();
        case ($urandom_range(0, 6))
            0: it.has_data = 1'b0;
            1: it.section_bytes = '0;
            2: it.section_alignment = rand64();
            3: it.section_alignment = aslc_pkg::W'(1) << $urandom_range(0, 5);
            4: it.record_total = it.record_total + 1'b1;
            5: it.section_bytes = rand64() | (aslc_pkg::W'(1) << 63);
            default: it = section(1'($urandom), rand64(), rand64(), rand64(), rand64());
        endcase
        return it;
    endfunction

    task automatic offer_section(input aslc_pkg::t_item it);
        int gap;
        gap = 0;
        if (!calm && tx_gappy && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {it.record_total, it.record_size, it.section_alignment,
                          it.section_bytes};
        s_axis_tuser  <= it.has_data;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
        if (sent % 64 == 0) tx_gappy = 1'($urandom_range(0, 1));
    endtask

    task automatic load_count(input logic [8:0] n);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
        repeat (6) @(posedge i_clk);
        i_cfg_wdata <= n;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : drain
        int   hold;
        int   stretch;
        logic rx_gappy;
        rx_gappy = 1'b1;
        stretch  = 0;
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                for (hold = 0; hold < 300; hold++) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && rx_gappy && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
            stretch++;
            if (stretch % 80 == 0) rx_gappy = 1'($urandom_range(0, 1));
        end
    end

    initial begin : stimulus
        logic [8:0] n_count;
        int         pick;
        int         batch_items;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The reset count of one makes every section a batch of its own.
        offer_section(section(1'b1, 64'd1000, 64'd64, '0, '0));
        offer_section(section(1'b0, 64'd1000, 64'd64, '0, '0));
        offer_section(section(1'b1, 64'd0, 64'd64, '0, '0));
        offer_section(section(1'b1, 64'd1000, 64'd0, '0, '0));
        offer_section(section(1'b1, 64'd1000, 64'd96, '0, '0));
        offer_section(section(1'b1, 64'd1000, 64'd32, '0, '0));
        offer_section(section(1'b1, 64'd1, 64'h8000_0000_0000_0000, '0, '0));
        offer_section(section(1'b1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, '0, '0));
        offer_section(section(1'b1, 64'd80, 64'd64, 64'd0, 64'd5));
        offer_section(section(1'b1, 64'd80, 64'd64, 64'd5, 64'd0));
        offer_section(section(1'b1, 64'd4096, 64'd64, 64'h1_0000_0000, 64'h1_0000_0000));
        offer_section(section(1'b1, 64'd128, 64'd64, 64'd16, 64'd8));
        offer_section(section(1'b1, 64'd129, 64'd64, 64'd16, 64'd8));
        offer_section(section(1'b1, '1, '1, '1, '1));

        // The first section ends at the top of the address space, so the next cannot align.
        load_count(9'd2);
        offer_section(section(1'b1, {aslc_pkg::W{1'b1}} - 64'd512, 64'd64, '0, '0));
        offer_section(section(1'b1, 64'd1, 64'd64, '0, '0));
        offer_section(section(1'b0, 64'd100, 64'd64, '0, '0));
        offer_section(section(1'b1, 64'd100, 64'd64, '0, '0));

        load_count(9'd0);
        offer_section(section(1'b1, 64'd100, 64'd64, '0, '0));
        offer_section(section(1'b1, 64'd100, 64'd128, '0, '0));

        // A count of one written in the middle of an oversized batch ends it at once.
        load_count(9'd511);
        offer_section(section(1'b1, 64'd100, 64'd64, '0, '0));
        offer_section(section(1'b1, 64'd100, 64'd64, '0, '0));
        load_count(9'd1);
        offer_section(section(1'b1, 64'd100, 64'd64, '0, '0));

        while (sent < 1420) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      n_count = 9'($urandom_range(1, 16));
            else if (pick < 76) n_count = 9'd1;
            else if (pick < 82) n_count = 9'd0;
            else if (pick < 86) n_count = 9'd257;
            else if (pick < 91) n_count = 9'($urandom_range(258, 511));
            else if (pick < 94) n_count = 9'(aslc_pkg::MAX_SECTIONS);
            else                n_count = 9'($urandom_range(17, 255));
            load_count(n_count);
            if (n_count == 0 || n_count > aslc_pkg::MAX_SECTIONS)
                batch_items = $urandom_range(3, 20);
            else
                batch_items = n_count * $urandom_range(1, (n_count > 40) ? 1 : 40 / n_count);
            repeat (batch_items) begin
                if (!hold_used && sent >= 500) begin
                    hold_used = 1'b1;
                    hold_req  = 1'b1;
                end
                if (sent >= 1250) calm = 1'b1;
                offer_section(($urandom_range(0, 24) == 0) ? rough_section() : tidy_section());
            end
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
        repeat (10) @(posedge i_clk);
        if (fault_total == 0)
            $display("aligned_section_layout_checker_tb: clean");
        else
            $display("aligned_section_layout_checker_tb: errors");
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("aligned_section_layout_checker_tb: errors");
        $finish;
    end

endmodule

### files.f
rtl/core/aslc_pkg.sv
rtl/core/aslc_mul_stage.sv
rtl/core/aslc_rule_stage.sv
rtl/core/aslc_place.sv
rtl/core/aligned_section_layout_checker.sv
verif/aslc_layout_check.sv
verif/aligned_section_layout_checker_tb.sv
